// ===== hw/rtl/servo_status_packet_checker_defines.svh =====
// Assertion macros used by the file that checks this block.
`ifndef SERVO_STATUS_PACKET_CHECKER_DEFINES_SVH
`define SERVO_STATUS_PACKET_CHECKER_DEFINES_SVH

// Checked only while reset is released.
`define SSPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SSPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sspc_pkg.sv =====
package sspc_pkg;

    localparam int CNT_W = 9;

    localparam logic [CNT_W-1:0] IDX_HDR0      = CNT_W'(0);
    localparam logic [CNT_W-1:0] IDX_HDR1      = CNT_W'(1);
    localparam logic [CNT_W-1:0] IDX_ID        = CNT_W'(2);
    localparam logic [CNT_W-1:0] IDX_LENGTH    = CNT_W'(3);
    localparam logic [CNT_W-1:0] IDX_ERROR     = CNT_W'(4);
    localparam logic [CNT_W-1:0] IDX_PARAM_LO  = CNT_W'(5);
    localparam logic [CNT_W-1:0] IDX_PARAM_HI  = CNT_W'(6);
    localparam logic [CNT_W-1:0] MIN_PACKET    = CNT_W'(6);
    localparam logic [CNT_W-1:0] LENGTH_OFFSET = CNT_W'(4);
    localparam logic [7:0]       HEADER_BYTE   = 8'hFF;

    localparam logic [2:0] VERDICT_OK        = 3'd0;
    localparam logic [2:0] VERDICT_SHORT     = 3'd1;
    localparam logic [2:0] VERDICT_BAD_HDR   = 3'd2;
    localparam logic [2:0] VERDICT_BAD_CSUM  = 3'd3;
    localparam logic [2:0] VERDICT_BAD_LEN   = 3'd4;
    localparam logic [2:0] VERDICT_DEV_ERROR = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] verdict;
        logic [7:0] servo_id;
        logic [7:0] device_error;
        logic [7:0] param_low;
        logic [7:0] param_high;
    } t_out_item;

endpackage

// ===== hw/rtl/sspc_frame.sv =====
module sspc_frame #(
    parameter int MAX_PACKET_BYTES = 259
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  sspc_pkg::t_in_item i_item,
    output sspc_pkg::t_out_item o_result
);
    import sspc_pkg::*;

    localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_PACKET_BYTES);

    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_sum;
    logic             r_hdr_good;
    logic [7:0]       r_id;
    logic [7:0]       r_len;
    logic [7:0]       r_err;
    logic [7:0]       r_plo;
    logic [7:0]       r_phi;

    logic [CNT_W-1:0] n_count;
    logic [7:0]       n_sum;
    logic             n_hdr_good;
    logic [7:0]       n_id;
    logic [7:0]       n_len;
    logic [7:0]       n_err;
    logic [7:0]       n_plo;
    logic [7:0]       n_phi;
    logic             indexed;
    logic [7:0]       rx;

    assign rx      = i_item.rx_byte;
    assign indexed = r_count < MaxCnt;

    always_comb begin
        n_count    = indexed ? r_count + CNT_W'(1) : r_count;
        n_hdr_good = r_hdr_good &
                     !(indexed && (r_count == IDX_HDR0 || r_count == IDX_HDR1) &&
                       rx != HEADER_BYTE);
        n_id  = (indexed && r_count == IDX_ID)       ? rx : r_id;
        n_len = (indexed && r_count == IDX_LENGTH)   ? rx : r_len;
        n_err = (indexed && r_count == IDX_ERROR)    ? rx : r_err;
        n_plo = (indexed && r_count == IDX_PARAM_LO) ? rx : r_plo;
        n_phi = (indexed && r_count == IDX_PARAM_HI) ? rx : r_phi;
        n_sum = (!indexed || r_count >= IDX_ID) ? r_sum + rx : r_sum;
    end

    always_comb begin
        o_result.servo_id     = n_id;
        o_result.device_error = n_err;
        o_result.param_low    = n_plo;
        o_result.param_high   = n_phi;
        if (n_count < MIN_PACKET) begin
            o_result.verdict = VERDICT_SHORT;
        end else if (!n_hdr_good) begin
            o_result.verdict = VERDICT_BAD_HDR;
        end else if (~r_sum != rx) begin
            o_result.verdict = VERDICT_BAD_CSUM;
        end else if (CNT_W'(n_len) + LENGTH_OFFSET != n_count) begin
            o_result.verdict = VERDICT_BAD_LEN;
        end else if (n_err != 8'd0) begin
            o_result.verdict = VERDICT_DEV_ERROR;
        end else begin
            o_result.verdict = VERDICT_OK;
        end
    end

    // The last byte of a packet returns the tracker to its reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_hdr_good <= 1'b1;
            r_id       <= '0;
            r_len      <= '0;
            r_err      <= '0;
            r_plo      <= '0;
            r_phi      <= '0;
        end else if (i_step) begin
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_hdr_good <= n_hdr_good;
            r_id       <= n_id;
            r_len      <= n_len;
            r_err      <= n_err;
            r_plo      <= n_plo;
            r_phi      <= n_phi;
        end
    end

endmodule

// ===== hw/rtl/servo_status_packet_checker.sv =====
// Channel   Direction  Signals                     Moves
// input     in         i_valid, o_stall, i_data    one packet byte per transaction
// output    out        o_valid, i_stall, o_data    one verdict per packet
//
// One byte is accepted every cycle unless o_stall is high; each byte is held in the input register.
// The verdict is loaded into the output register at the edge at which the last byte
// leaves the input register, so o_valid follows the input and the output register.
// Synchronous active-low reset empties both registers and clears the packet state.
// o_stall rises only while a last byte waits behind a full, stalled output register.
module servo_status_packet_checker #(
    parameter int MAX_PACKET_BYTES = 259
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sspc_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output sspc_pkg::t_out_item o_data
);
    import sspc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item frame_result;
    logic      out_free;
    logic      step;
    logic      in_take;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && (!r_in.last_byte || out_free);
    assign in_take  = !r_in_valid || step;
    assign o_stall  = !in_take;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    sspc_frame #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .o_result(frame_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_valid) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.last_byte) begin
            r_out <= frame_result;
        end
    end

endmodule

// ===== hw/rtl/sspc_checker.sv =====
`include "servo_status_packet_checker_defines.svh"

module sspc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input sspc_pkg::t_out_item o_data
);
    import sspc_pkg::*;

    `SSPC_ASSERT_ALWAYS(a_idle_after_reset, !i_rst_n |=> !o_valid, "o_valid after reset")
    `SSPC_ASSERT(a_out_held, o_valid && i_stall |=> o_valid && $stable(o_data), "stalled result changed")
    `SSPC_ASSERT(a_ok_no_error, o_valid && o_data.verdict == VERDICT_OK |-> o_data.device_error == 8'd0, "ok verdict with device error")
    `SSPC_ASSERT(a_dev_err_set, o_valid && o_data.verdict == VERDICT_DEV_ERROR |-> o_data.device_error != 8'd0, "device error verdict with zero error byte")
    `SSPC_ASSERT(a_stall_needs_full, o_stall |-> o_valid && i_stall, "input stalled while output can drain")

endmodule

bind servo_status_packet_checker sspc_checker u_sspc_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data (o_data)
);
